// ===== hdl/peu_pkg.sv =====
// Shared types, constants and helpers for the particle Euler update block.
`default_nettype none

package peu_pkg;

    localparam int STAGES    = 5;
    localparam int Q_W       = 16;
    localparam int COL_W     = 9;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int IN_W      = 160;
    localparam int OUT_W     = 144;

    localparam logic [COL_W-1:0] COL_FULL = 9'd256;

    localparam int MODE_WIND  = 0;
    localparam int MODE_GRAV  = 1;
    localparam int MODE_DTSQ  = 2;
    localparam int MODE_DYING = 3;

    localparam logic [3:0]       MODE_RST   = 4'd12;
    localparam logic [CFG_W-1:0] WIND_RST   = 48'h0000_0000_0400;
    localparam logic [CFG_W-1:0] GRAV_RST   = 48'h0000_F632_0000;
    localparam logic [CFG_W-1:0] COLOUR_RST = 48'h0000_0000_0000;
    localparam logic [Q_W-1:0]   LIFE_RST   = 16'hFFFD;

    typedef logic signed [Q_W-1:0] q78_t;
    typedef logic [COL_W-1:0]      colour_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE   = 3'd0,
        REG_WIND   = 3'd1,
        REG_GRAV   = 3'd2,
        REG_COLOUR = 3'd3,
        REG_LIFE   = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [STAGES-1:0] en;
    } pipe_ctl_t;

    function automatic q78_t sat16(input logic signed [19:0] v);
        q78_t r;
        if (v > 20'sd32767)
            r = 16'sh7FFF;
        else if (v < -20'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/peu_ctrl.sv =====
// Valid/ready chain for the pipeline stages.
`default_nettype none

module peu_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output peu_pkg::pipe_ctl_t       ctl
);

    logic [peu_pkg::STAGES-1:0] v_reg;
    logic [peu_pkg::STAGES-1:0] v_next;
    logic [peu_pkg::STAGES-1:0] rdy;

    always_comb
    begin
        rdy[peu_pkg::STAGES-1] = !v_reg[peu_pkg::STAGES-1] || out_ready;
        for (int i = peu_pkg::STAGES-2; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
        ctl.en[0] = in_valid && rdy[0];
        v_next[0] = rdy[0] ? in_valid : v_reg[0];
        for (int i = 1; i < peu_pkg::STAGES; i++)
        begin
            ctl.en[i] = v_reg[i-1] && rdy[i];
            v_next[i] = rdy[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[peu_pkg::STAGES-1];

endmodule

`default_nettype wire

// ===== hdl/peu_common.sv =====
// Life, dead flag, colour and time-step stages shared by all three axes.
`default_nettype none

module peu_common (
    input  wire logic                                clk,
    input  wire peu_pkg::pipe_ctl_t                  ctl,
    input  wire logic [3:0]                          mode,
    input  wire logic [peu_pkg::CFG_W-1:0]           colour_step,
    input  wire logic [peu_pkg::Q_W-1:0]             life_step,
    input  wire peu_pkg::q78_t                       life_in,
    input  wire logic [peu_pkg::Q_W-1:0]             dt_in,
    input  wire logic [2:0][peu_pkg::COL_W-1:0]      col_in,
    output logic [peu_pkg::Q_W-1:0]                  factor,
    output logic [peu_pkg::Q_W-1:0]                  dt_late,
    output logic [peu_pkg::STAGES-1:0]               dead_pipe,
    output peu_pkg::q78_t                            life_out,
    output logic [2:0][peu_pkg::COL_W-1:0]           col_out
);

    logic [peu_pkg::Q_W-1:0]           dt_reg [3];
    logic [31:0]                       dtsq_reg;
    peu_pkg::q78_t                     life_reg [peu_pkg::STAGES];
    logic [peu_pkg::STAGES-1:0]        dead_reg;
    logic [2:0][peu_pkg::COL_W-1:0]    col_reg [peu_pkg::STAGES];

    peu_pkg::q78_t                     life_next;
    logic                              dead_next;
    logic [2:0][peu_pkg::COL_W-1:0]    col_next;
    logic signed [17:0]                csum;
    logic [32:0]                       dtsq_rnd;

    always_comb
    begin
        life_next = peu_pkg::sat16(20'($signed(life_in)) + 20'($signed(life_step)));
        dead_next = mode[peu_pkg::MODE_DYING] && (life_next <= 16'sd0);
        for (int k = 0; k < 3; k++)
        begin
            csum = $signed({9'b0, col_in[k]}) + 18'($signed(colour_step[16*k +: 16]));
            if (dead_next)
                col_next[k] = col_in[k];
            else if (csum < 18'sd0)
                col_next[k] = '0;
            else if (csum > 18'sd256)
                col_next[k] = peu_pkg::COL_FULL;
            else
                col_next[k] = csum[peu_pkg::COL_W-1:0];
        end
        dtsq_rnd = 33'(dtsq_reg) + 33'd32768;
        factor   = mode[peu_pkg::MODE_DTSQ] ? dtsq_rnd[31:16] : dt_reg[0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[0])
        begin
            dt_reg[0]   <= dt_in;
            dtsq_reg    <= dt_in * dt_in;
            life_reg[0] <= life_next;
            dead_reg[0] <= dead_next;
            col_reg[0]  <= col_next;
        end
        for (int i = 1; i < peu_pkg::STAGES; i++)
        begin
            if (ctl.en[i])
            begin
                life_reg[i] <= life_reg[i-1];
                dead_reg[i] <= dead_reg[i-1];
                col_reg[i]  <= col_reg[i-1];
            end
        end
        if (ctl.en[1])
            dt_reg[1] <= dt_reg[0];
        if (ctl.en[2])
            dt_reg[2] <= dt_reg[1];
    end

    assign dt_late   = dt_reg[2];
    assign dead_pipe = dead_reg;
    assign life_out  = life_reg[peu_pkg::STAGES-1];
    assign col_out   = col_reg[peu_pkg::STAGES-1];

endmodule

`default_nettype wire

// ===== hdl/peu_axis.sv =====
// Velocity and position stages for one axis.
`default_nettype none

module peu_axis (
    input  wire logic                        clk,
    input  wire peu_pkg::pipe_ctl_t          ctl,
    input  wire logic [3:0]                  mode,
    input  wire logic [peu_pkg::Q_W-1:0]     wind,
    input  wire logic [peu_pkg::Q_W-1:0]     grav,
    input  wire peu_pkg::q78_t               pos_in,
    input  wire peu_pkg::q78_t               vel_in,
    input  wire logic [peu_pkg::Q_W-1:0]     factor,
    input  wire logic [peu_pkg::Q_W-1:0]     dt_late,
    input  wire logic [peu_pkg::STAGES-1:0]  dead_pipe,
    output peu_pkg::q78_t                    pos_out,
    output peu_pkg::q78_t                    vel_out
);

    peu_pkg::q78_t        pos_reg [peu_pkg::STAGES];
    peu_pkg::q78_t        vel_reg [peu_pkg::STAGES];
    peu_pkg::q78_t        acc_reg;
    logic signed [33:0]   prod_a_reg;
    logic signed [33:0]   prod_v_reg;

    logic signed [19:0]   acc_sum;
    logic signed [16:0]   fac_s;
    logic signed [16:0]   dt_s;
    logic signed [33:0]   rnd_a;
    logic signed [33:0]   rnd_v;
    peu_pkg::q78_t        vel_new;
    peu_pkg::q78_t        pos_new;

    always_comb
    begin
        acc_sum = '0;
        if (mode[peu_pkg::MODE_WIND])
            acc_sum = acc_sum + 20'($signed(wind));
        if (mode[peu_pkg::MODE_GRAV])
            acc_sum = acc_sum + 20'($signed(grav));
        fac_s   = $signed({1'b0, factor});
        dt_s    = $signed({1'b0, dt_late});
        rnd_a   = (prod_a_reg + 34'sd32768) >>> 16;
        rnd_v   = (prod_v_reg + 34'sd32768) >>> 16;
        vel_new = dead_pipe[1] ? vel_reg[1]
                               : peu_pkg::sat16(20'(vel_reg[1]) + 20'(rnd_a));
        pos_new = dead_pipe[3] ? pos_reg[3]
                               : peu_pkg::sat16(20'(pos_reg[3]) + 20'(rnd_v));
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[0])
        begin
            pos_reg[0] <= pos_in;
            vel_reg[0] <= vel_in;
            acc_reg    <= peu_pkg::sat16(acc_sum);
        end
        if (ctl.en[1])
        begin
            pos_reg[1] <= pos_reg[0];
            vel_reg[1] <= vel_reg[0];
            prod_a_reg <= acc_reg * fac_s;
        end
        if (ctl.en[2])
        begin
            pos_reg[2] <= pos_reg[1];
            vel_reg[2] <= vel_new;
        end
        if (ctl.en[3])
        begin
            pos_reg[3] <= pos_reg[2];
            vel_reg[3] <= vel_reg[2];
            prod_v_reg <= vel_reg[2] * dt_s;
        end
        if (ctl.en[4])
        begin
            pos_reg[4] <= pos_new;
            vel_reg[4] <= vel_reg[3];
        end
    end

    assign pos_out = pos_reg[peu_pkg::STAGES-1];
    assign vel_out = vel_reg[peu_pkg::STAGES-1];

endmodule

`default_nettype wire

// ===== hdl/particle_euler_update_top.sv =====
// Top level of the particle Euler update block.
//
// One particle request enters on the s_ side (s_tvalid/s_tready/s_tdata) and
// one updated particle leaves on the m_ side; m_tuser carries the dead flag.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata, one
// register per cycle; the user must write them only while the pipeline is
// empty; the block itself does not enforce this. There are five register
// stages (acceleration and dt squared, acceleration product, velocity,
// velocity product, position); m_tvalid is the last stage's valid bit.
// Throughput: one request per cycle unless m_tready stalls the output; each
// stage moves on when the next one is free, so bubbles close up and the
// input keeps flowing while a finished result waits in the output stage.
// When m_tready stays low the stages fill and s_tready falls once all five
// hold a request; nothing is dropped or repeated.
// Reset clears all valid bits and loads the register defaults: dying and
// dt squared on, wind x = 4.0, gravity y about -9.8, life step -3/256.
`default_nettype none

module particle_euler_update_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, red, green, blue, life,
    // time_step, zero pad
    input  wire logic [peu_pkg::IN_W-1:0]          s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
    // new_red, new_green, new_blue, new_life, zero pad
    output logic [peu_pkg::OUT_W-1:0]              m_tdata,
    // dead
    output logic [0:0]                             m_tuser,
    input  wire logic                              cfg_we,
    input  wire logic [peu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [peu_pkg::CFG_W-1:0]         cfg_wdata
);

    logic [3:0]                        mode_reg;
    logic [peu_pkg::CFG_W-1:0]         wind_reg;
    logic [peu_pkg::CFG_W-1:0]         grav_reg;
    logic [peu_pkg::CFG_W-1:0]         colour_reg;
    logic [peu_pkg::Q_W-1:0]           life_step_reg;

    peu_pkg::pipe_ctl_t                ctl;
    logic [peu_pkg::Q_W-1:0]           factor;
    logic [peu_pkg::Q_W-1:0]           dt_late;
    logic [peu_pkg::STAGES-1:0]        dead_pipe;
    peu_pkg::q78_t                     life_out;
    logic [2:0][peu_pkg::COL_W-1:0]    col_in;
    logic [2:0][peu_pkg::COL_W-1:0]    col_out;
    peu_pkg::q78_t                     pos_out [3];
    peu_pkg::q78_t                     vel_out [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= peu_pkg::MODE_RST;
            wind_reg      <= peu_pkg::WIND_RST;
            grav_reg      <= peu_pkg::GRAV_RST;
            colour_reg    <= peu_pkg::COLOUR_RST;
            life_step_reg <= peu_pkg::LIFE_RST;
        end
        else if (cfg_we)
        begin
            case (peu_pkg::cfg_reg_t'(cfg_index))
                peu_pkg::REG_MODE:   mode_reg      <= cfg_wdata[3:0];
                peu_pkg::REG_WIND:   wind_reg      <= cfg_wdata;
                peu_pkg::REG_GRAV:   grav_reg      <= cfg_wdata;
                peu_pkg::REG_COLOUR: colour_reg    <= cfg_wdata;
                peu_pkg::REG_LIFE:   life_step_reg <= cfg_wdata[15:0];
                default:             ;
            endcase
        end
    end

    peu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .ctl       (ctl)
    );

    assign col_in[0] = s_tdata[104:96];
    assign col_in[1] = s_tdata[113:105];
    assign col_in[2] = s_tdata[122:114];

    peu_common u_common (
        .clk         (clk),
        .ctl         (ctl),
        .mode        (mode_reg),
        .colour_step (colour_reg),
        .life_step   (life_step_reg),
        .life_in     (s_tdata[138:123]),
        .dt_in       (s_tdata[154:139]),
        .col_in      (col_in),
        .factor      (factor),
        .dt_late     (dt_late),
        .dead_pipe   (dead_pipe),
        .life_out    (life_out),
        .col_out     (col_out)
    );

    for (genvar k = 0; k < 3; k++)
    begin : g_axis
        peu_axis u_axis (
            .clk       (clk),
            .ctl       (ctl),
            .mode      (mode_reg),
            .wind      (wind_reg[16*k +: 16]),
            .grav      (grav_reg[16*k +: 16]),
            .pos_in    (s_tdata[16*k +: 16]),
            .vel_in    (s_tdata[48 + 16*k +: 16]),
            .factor    (factor),
            .dt_late   (dt_late),
            .dead_pipe (dead_pipe),
            .pos_out   (pos_out[k]),
            .vel_out   (vel_out[k])
        );
    end

    assign m_tdata = {5'b0, life_out, col_out[2], col_out[1], col_out[0],
                      vel_out[2], vel_out[1], vel_out[0],
                      pos_out[2], pos_out[1], pos_out[0]};
    assign m_tuser = dead_pipe[peu_pkg::STAGES-1];

    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while output side free");

    a_dead_needs_dying: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> mode_reg[peu_pkg::MODE_DYING])
        else $error("dead flag with dying disabled");

    a_dead_life: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> ($signed(m_tdata[138:123]) <= 16'sd0))
        else $error("dead flag with positive life");

    a_colour_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |->
            (m_tdata[104:96] <= peu_pkg::COL_FULL && m_tdata[113:105] <= peu_pkg::COL_FULL
             && m_tdata[122:114] <= peu_pkg::COL_FULL))
        else $error("live colour out of range");

endmodule

`default_nettype wire

// ===== verif/peu_tb_pkg.sv =====
// Request and update types, plus the scoreboard that predicts and checks particle updates.
`timescale 1ns / 1ps

package peu_tb_pkg;

    import peu_pkg::*;

    // lowest field last: pos_x sits in bits 15:0
    typedef struct packed {
        logic [4:0]     pad;
        logic [Q_W-1:0] time_step;
        q78_t           life;
        colour_t        blue;
        colour_t        green;
        colour_t        red;
        q78_t           vel_z;
        q78_t           vel_y;
        q78_t           vel_x;
        q78_t           pos_z;
        q78_t           pos_y;
        q78_t           pos_x;
    } particle_in_t;

    typedef struct packed {
        logic [4:0] pad;
        q78_t       new_life;
        colour_t    new_blue;
        colour_t    new_green;
        colour_t    new_red;
        q78_t       new_vel_z;
        q78_t       new_vel_y;
        q78_t       new_vel_x;
        q78_t       new_pos_z;
        q78_t       new_pos_y;
        q78_t       new_pos_x;
    } particle_out_t;

    typedef struct packed {
        logic          dead;
        particle_out_t upd;
    } particle_update_t;

    class particle_scoreboard;
        logic [3:0]       mode;
        logic [CFG_W-1:0] wind;
        logic [CFG_W-1:0] gravity;
        logic [CFG_W-1:0] colour_step;
        q78_t             life_step;
        particle_update_t updates_q[$];
        int               errors;

        function new();
            mode        = 4'd12;
            wind        = 48'h0000_0000_0400;
            gravity     = 48'h0000_F632_0000;
            colour_step = '0;
            life_step   = -16'sd3;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_MODE:   mode        = value[3:0];
                REG_WIND:   wind        = value;
                REG_GRAV:   gravity     = value;
                REG_COLOUR: colour_step = value;
                REG_LIFE:   life_step   = q78_t'(value[Q_W-1:0]);
                default:    ;
            endcase
        endfunction

        function int pending();
            return updates_q.size();
        endfunction

        function longint saturate_q78(longint v);
            if (v > 32767)
                return 32767;
            if (v < -32768)
                return -32768;
            return v;
        endfunction

        // nearest, ties upwards
        function longint round_q16(longint v);
            return (v + 32768) >>> 16;
        endfunction

        function void note_request(particle_in_t p);
            particle_update_t want;
            q78_t             pos_in[3];
            q78_t             vel_in[3];
            colour_t          col_in[3];
            q78_t             pos_out[3];
            q78_t             vel_out[3];
            colour_t          col_out[3];
            longint           life_sum;
            longint           dt;
            longint           factor;
            longint           accel;
            longint           vel;
            longint           pos;
            longint           c;
            pos_in   = '{p.pos_x, p.pos_y, p.pos_z};
            vel_in   = '{p.vel_x, p.vel_y, p.vel_z};
            col_in   = '{p.red, p.green, p.blue};
            life_sum = saturate_q78(longint'(p.life) + longint'(life_step));
            dt       = longint'(p.time_step);
            want     = '0;
            want.dead = (life_sum <= 0) && mode[MODE_DYING];
            want.upd.new_life = q78_t'(life_sum);
            if (want.dead)
            begin
                pos_out = pos_in;
                vel_out = vel_in;
                col_out = col_in;
            end
            else
            begin
                factor = mode[MODE_DTSQ] ? (dt * dt + 32768) >>> 16 : dt;
                for (int k = 0; k < 3; k++)
                begin
                    accel = 0;
                    if (mode[MODE_WIND])
                        accel += longint'($signed(wind[16*k +: 16]));
                    if (mode[MODE_GRAV])
                        accel += longint'($signed(gravity[16*k +: 16]));
                    accel = saturate_q78(accel);
                    vel = saturate_q78(longint'(vel_in[k]) + round_q16(accel * factor));
                    pos = saturate_q78(longint'(pos_in[k]) + round_q16(vel * dt));
                    vel_out[k] = q78_t'(vel);
                    pos_out[k] = q78_t'(pos);
                    c = longint'(col_in[k]) + longint'($signed(colour_step[16*k +: 16]));
                    if (c > longint'(COL_FULL))
                        c = longint'(COL_FULL);
                    if (c < 0)
                        c = 0;
                    col_out[k] = colour_t'(c);
                end
            end
            want.upd.new_pos_x = pos_out[0];
            want.upd.new_pos_y = pos_out[1];
            want.upd.new_pos_z = pos_out[2];
            want.upd.new_vel_x = vel_out[0];
            want.upd.new_vel_y = vel_out[1];
            want.upd.new_vel_z = vel_out[2];
            want.upd.new_red   = col_out[0];
            want.upd.new_green = col_out[1];
            want.upd.new_blue  = col_out[2];
            updates_q.push_back(want);
        endfunction

        function void compare(string field, longint want, longint got);
            if (want != got)
            begin
                errors++;
                $error("%s: expected %0d, got %0d", field, want, got);
            end
        endfunction

        function void check_result(particle_out_t got, logic got_dead);
            particle_update_t want;
            if (updates_q.size() == 0)
            begin
                errors++;
                $error("update returned with no request outstanding");
                return;
            end
            want = updates_q.pop_front();
            compare("new_pos_x", want.upd.new_pos_x, got.new_pos_x);
            compare("new_pos_y", want.upd.new_pos_y, got.new_pos_y);
            compare("new_pos_z", want.upd.new_pos_z, got.new_pos_z);
            compare("new_vel_x", want.upd.new_vel_x, got.new_vel_x);
            compare("new_vel_y", want.upd.new_vel_y, got.new_vel_y);
            compare("new_vel_z", want.upd.new_vel_z, got.new_vel_z);
            compare("new_red", want.upd.new_red, got.new_red);
            compare("new_green", want.upd.new_green, got.new_green);
            compare("new_blue", want.upd.new_blue, got.new_blue);
            compare("new_life", want.upd.new_life, got.new_life);
            compare("dead", want.dead, got_dead);
        endfunction
    endclass

endpackage

// ===== verif/tb_top.sv =====
// Testbench top: drives particle requests and register writes, checks every update.
`timescale 1ns / 1ps

module tb_top;

    import peu_pkg::*;
    import peu_tb_pkg::*;

    localparam int NUM_PHASES     = 10;
    localparam int RAND_PER_PHASE = 133;
    localparam int MAX_WAIT       = 17;
    localparam int NUM_REGS       = 5;
    localparam int CYCLE_LIMIT    = 500000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;
    logic [0:0]         m_tuser;
    logic               cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]   cfg_wdata;

    particle_scoreboard sb;
    bit                 tx_calm;
    bit                 rx_calm;
    int                 cycle_count = 0;

    particle_euler_update_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser[0]);
        end
    end

    function automatic q78_t rand_q78(bit tame);
        if (tame)
            return q78_t'(int'($urandom_range(0, 2047)) - 1024);
        return q78_t'($urandom);
    endfunction

    function automatic colour_t rand_colour();
        if ($urandom_range(0, 7) == 0)
            return colour_t'($urandom);
        return colour_t'($urandom_range(0, 256));
    endfunction

    function automatic logic [CFG_W-1:0] rand_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[CFG_W-1:0];
    endfunction

    function automatic logic [CFG_W-1:0] rand_lanes();
        if ($urandom_range(0, 1) == 0)
            return rand_word();
        return {rand_q78(1'b1), rand_q78(1'b1), rand_q78(1'b1)};
    endfunction

    function automatic logic [CFG_W-1:0] mode_word(bit wind, bit grav, bit dtsq, bit dying);
        logic [CFG_W-1:0] w;
        w             = '0;
        w[MODE_WIND]  = wind;
        w[MODE_GRAV]  = grav;
        w[MODE_DTSQ]  = dtsq;
        w[MODE_DYING] = dying;
        return w;
    endfunction

    function automatic particle_in_t particle_of(int px, int py, int pz, int vx, int vy, int vz,
                                                 int r, int g, int b, int life, int dt);
        particle_in_t p;
        p           = '0;
        p.pos_x     = q78_t'(px);
        p.pos_y     = q78_t'(py);
        p.pos_z     = q78_t'(pz);
        p.vel_x     = q78_t'(vx);
        p.vel_y     = q78_t'(vy);
        p.vel_z     = q78_t'(vz);
        p.red       = colour_t'(r);
        p.green     = colour_t'(g);
        p.blue      = colour_t'(b);
        p.life      = q78_t'(life);
        p.time_step = Q_W'(dt);
        return p;
    endfunction

    function automatic particle_in_t rand_particle();
        particle_in_t p;
        bit           tame;
        tame    = $urandom_range(0, 2) != 0;
        p       = '0;
        p.pos_x = rand_q78(tame);
        p.pos_y = rand_q78(tame);
        p.pos_z = rand_q78(tame);
        p.vel_x = rand_q78(tame);
        p.vel_y = rand_q78(tame);
        p.vel_z = rand_q78(tame);
        p.red   = rand_colour();
        p.green = rand_colour();
        p.blue  = rand_colour();
        case ($urandom_range(0, 3))
            0:       p.life = q78_t'($urandom);
            // straddle the expiry point for the current life step
            1:       p.life = q78_t'(-longint'(sb.life_step) + longint'($urandom_range(0, 8)) - 4);
            default: p.life = q78_t'($urandom_range(1, 32767));
        endcase
        p.time_step = tame ? Q_W'($urandom_range(0, 4095)) : Q_W'($urandom);
        return p;
    endfunction

    task automatic send_particle(particle_in_t p);
        if ($urandom_range(0, 39) == 0)
            tx_calm = !tx_calm;
        repeat (tx_calm ? 0 : $urandom_range(0, MAX_WAIT))
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = p;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic wait_for_updates();
        @(negedge clk);
        s_tvalid = 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        sb.write_reg(idx, value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_directed();
        send_particle(particle_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_particle(particle_of(32767, 32767, 32767, 32767, 32767, 32767,
                                  256, 256, 256, 32767, 65535));
        send_particle(particle_of(-32768, -32768, -32768, -32768, -32768, -32768,
                                  0, 0, 0, -32768, 65535));
        // life lands exactly on zero, then one above, with the default step
        send_particle(particle_of(100, -100, 0, 50, -50, 0, 128, 128, 128, 3, 4096));
        send_particle(particle_of(100, -100, 0, 50, -50, 0, 128, 128, 128, 4, 4096));
        // half-lsb products and colour above full
        send_particle(particle_of(0, 0, 0, 1, -1, 3, 511, 257, 300, 1000, 32768));
        send_particle(particle_of(32700, -32700, 0, 32767, -32768, 0, 0, 256, 1, 1000, 65535));
        send_particle(particle_of(21845, -21846, 21845, -21846, 21845, -21846,
                                  341, 170, 341, 21845, 43690));
        send_particle(particle_of(-21846, 21845, -21846, 21845, -21846, 21845,
                                  170, 341, 170, -21846, 21845));
        send_particle(particle_of(5, -7, 9, 256, -256, 1, 10, 20, 30, 200, 1));
        send_particle(particle_of(-1, 1, -1, -1, 1, -1, 255, 1, 0, 1, 65535));
        send_particle(particle_of(0, 0, 0, 32767, -32768, 12345, 0, 0, 0, -3, 0));
    endtask

    task automatic set_phase(int ph);
        case (ph)
            1:
            begin
                write_cfg(REG_MODE, mode_word(1'b1, 1'b1, 1'b1, 1'b1));
                write_cfg(REG_WIND, {3{16'h7FFF}});
                write_cfg(REG_GRAV, {3{16'h7FFF}});
                write_cfg(REG_COLOUR, {3{16'h7FFF}});
                write_cfg(REG_LIFE, 48'h7FFF);
            end
            2:
            begin
                write_cfg(REG_MODE, mode_word(1'b1, 1'b1, 1'b1, 1'b0));
                write_cfg(REG_WIND, {3{16'h8000}});
                write_cfg(REG_GRAV, {3{16'h8000}});
                write_cfg(REG_COLOUR, {3{16'h8000}});
                write_cfg(REG_LIFE, 48'h8000);
            end
            3:
            begin
                write_cfg(REG_MODE, mode_word(1'b0, 1'b0, 1'b0, 1'b1));
                write_cfg(REG_WIND, '0);
                write_cfg(REG_GRAV, '0);
                write_cfg(REG_COLOUR, '0);
                write_cfg(REG_LIFE, '0);
            end
            default:
            begin
                write_cfg(REG_MODE, rand_word());
                write_cfg(REG_WIND, rand_lanes());
                write_cfg(REG_GRAV, rand_lanes());
                write_cfg(REG_COLOUR, rand_lanes());
                write_cfg(REG_LIFE, rand_word());
                write_cfg(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)),
                          rand_word());
            end
        endcase
    endtask

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph > 0)
            begin
                wait_for_updates();
                set_phase(ph);
            end
            if (ph < 2)
                send_directed();
            repeat (RAND_PER_PHASE) send_particle(rand_particle());
        end
        wait_for_updates();
        repeat (STAGES + 2) @(posedge clk);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // update side: random back-pressure per update
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rx_calm = !rx_calm;
            repeat (rx_calm ? 0 : $urandom_range(0, MAX_WAIT))
            begin
                @(negedge clk);
                m_tready = 1'b0;
            end
            @(negedge clk);
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

endmodule
